// ----- design/sbp_pkg.sv -----
package sbp_pkg;

    localparam int OBJ_W   = 8;
    localparam int COORD_W = 16;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 9;
    localparam int EPOCH_W = 8;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'd255;

    localparam logic signed [27:0] HASH_PX = 28'sd73856093;
    localparam logic signed [27:0] HASH_PY = 28'sd19349663;
    localparam logic signed [27:0] HASH_PZ = 28'sd83492791;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_INSERT,
        OP_PAIR,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEARED,
        ST_INSERTED,
        ST_PRESENT,
        ST_POOL_FULL,
        ST_TABLE_FULL,
        ST_PAIR,
        ST_NO_PAIR
    } status_t;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_HASH_WAIT,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_CHAIN_RD,
        S_CHAIN_CHK,
        S_INS_WRITE,
        S_PAIR_POS,
        S_ACT_RD,
        S_BKT_RD,
        S_BKT_CHK,
        S_STAGE_RD,
        S_STAGE_CHK,
        S_WALK,
        S_READ_C,
        S_CMP,
        S_SEEN_RD,
        S_SEEN_CHK,
        S_RESULT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_XOR,
        H_MOD,
        H_DONE
    } hash_state_t;

    typedef struct packed {
        logic start;
        logic done;
    } hash_ctrl_t;

endpackage

// ----- design/sbp_ram.sv -----
module sbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/sbp_hash.sv -----
module sbp_hash
    import sbp_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hash_ctrl_t                     ctrl_in,
    output hash_ctrl_t                     ctrl_out,
    input  logic signed [COORD_W-1:0]      cell_x,
    input  logic signed [COORD_W-1:0]      cell_y,
    input  logic signed [COORD_W-1:0]      cell_z,
    output logic [KEY_W-1:0]               key,
    output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

    localparam int SW = $clog2(TABLE_SLOTS);
    localparam bit SLOT_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
    localparam logic [SW:0] SLOTS_W = (SW + 1)'(TABLE_SLOTS);

    hash_state_t state_reg, state_next;

    logic signed [43:0] px_reg, py_reg, pz_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SW-1:0]      rem_reg;
    logic [5:0]         bit_reg;
    logic [SW:0]        rem_shift;
    logic [SW-1:0]      rem_step;

    // one remainder bit per cycle for table sizes that are not a power of two
    assign rem_shift = {rem_reg, key_reg[bit_reg]};
    assign rem_step  = (rem_shift >= SLOTS_W) ? SW'(rem_shift - SLOTS_W) : rem_shift[SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            H_IDLE:
            begin
                if (ctrl_in.start)
                begin
                    state_next = H_XOR;
                end
            end
            H_XOR:
            begin
                state_next = H_MOD;
            end
            H_MOD:
            begin
                if (SLOT_POW2 || bit_reg == 6'd0)
                begin
                    state_next = H_DONE;
                end
            end
            H_DONE:
            begin
                state_next = H_IDLE;
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl_out.start = 1'b0;
        ctrl_out.done  = (state_reg == H_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            px_reg    <= '0;
            py_reg    <= '0;
            pz_reg    <= '0;
            key_reg   <= '0;
            rem_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                H_IDLE:
                begin
                    px_reg <= cell_x * HASH_PX;
                    py_reg <= cell_y * HASH_PY;
                    pz_reg <= cell_z * HASH_PZ;
                end
                H_XOR:
                begin
                    key_reg <= 64'(px_reg) ^ 64'(py_reg) ^ 64'(pz_reg);
                    rem_reg <= '0;
                    bit_reg <= 6'd63;
                end
                H_MOD:
                begin
                    if (SLOT_POW2)
                    begin
                        rem_reg <= key_reg[SW-1:0];
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        bit_reg <= bit_reg - 6'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign key  = key_reg;
    assign slot = rem_reg;

endmodule

// ----- design/spatial_hash_broadphase_pairs_unit.sv -----
// Spatial hash broadphase grid. Each transfer on the s side carries one operation and yields
// one transfer on the m side (operation 3 yields none). After reset the unit sweeps its bucket
// and pair memories before taking the first item. Clear sweeps the bucket memory. Insert
// hashes the cell (the remainder being formed one bit per cycle when TABLE_SLOTS is not a
// power of two), then probes slots and scans the chain, each step bounded by the single read
// port of the bucket and entry memories. Next pair visits buckets, stages their entries and
// tries candidate pairs. Every 255th clear or insert adds a sweep of the pair memory.
module spatial_hash_broadphase_pairs_unit
    import sbp_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024,
    parameter int ENTRY_POOL  = 4096,
    parameter int MAX_OBJECTS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // object_index, cell_x, cell_y, cell_z, zero pad
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // object_low, object_high, cell_occupancy, zero pad
    output logic [2:0]  m_tuser   // status
);

    localparam int SW    = $clog2(TABLE_SLOTS);
    localparam int AW    = $clog2(TABLE_SLOTS + 1);
    localparam int PW    = $clog2(ENTRY_POOL + 1);
    localparam int EIW   = $clog2(ENTRY_POOL);
    localparam int CW    = $clog2(MAX_OBJECTS + 1);
    localparam int SIW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int PAIRS = (MAX_OBJECTS * (MAX_OBJECTS - 1)) / 2;
    localparam int PIW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int SWEEP = (TABLE_SLOTS > PAIRS) ? TABLE_SLOTS : PAIRS;
    localparam int SWW   = $clog2(SWEEP + 1);
    localparam int BW    = 1 + KEY_W + PW + CNT_W;
    localparam int B_HEAD = CNT_W;
    localparam int B_KEY  = CNT_W + PW;
    localparam int B_VAL  = CNT_W + PW + KEY_W;

    localparam logic [PW-1:0]  CHAIN_END = PW'(ENTRY_POOL);
    localparam logic [AW-1:0]  SLOTS_A   = AW'(TABLE_SLOTS);
    localparam logic [SW-1:0]  SLOT_LAST = SW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0]  MAX_C     = CW'(MAX_OBJECTS);
    localparam logic [SWW-1:0] T_LAST    = SWW'(TABLE_SLOTS - 1);
    localparam logic [SWW-1:0] P_LAST    = SWW'(PAIRS - 1);

    ctrl_state_t state_reg, state_next;

    op_t                  op_reg;
    logic [OBJ_W-1:0]     obj_reg;
    logic [COORD_W-1:0]   x_reg, y_reg, z_reg;
    logic [SWW-1:0]       sweep_reg;
    logic                 sweep_b_reg, sweep_p_reg;
    logic [EPOCH_W-1:0]   epoch_reg;
    logic [SW-1:0]        probe_idx_reg;
    logic [AW-1:0]        probe_cnt_reg;
    logic [PW-1:0]        head_reg, cur_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [AW-1:0]        active_count_reg, walk_pos_reg;
    logic [PW-1:0]        pool_used_reg;
    logic [CW-1:0]        walk_first_reg, walk_second_reg, staged_count_reg;
    logic [OBJ_W-1:0]     obj_a_reg, lo_reg, hi_reg;
    logic [PIW-1:0]       pidx_reg;
    status_t              res_status_reg;
    logic [OBJ_W-1:0]     res_low_reg, res_high_reg;
    logic [CNT_W-1:0]     res_occ_reg;
    logic                 m_valid_reg;
    logic [2:0]           m_user_reg;
    logic [31:0]          m_data_reg;

    // memory ports
    logic                 b_we;
    logic [SW-1:0]        b_waddr, b_raddr;
    logic [BW-1:0]        b_wdata, b_rdata;
    logic                 a_we;
    logic [SW-1:0]        a_raddr, a_rdata;
    logic                 e_we;
    logic [EIW-1:0]       e_raddr;
    logic [OBJ_W+PW-1:0]  e_wdata, e_rdata;
    logic                 st_we;
    logic [SIW-1:0]       st_raddr;
    logic [OBJ_W-1:0]     st_rdata;
    logic                 p_we;
    logic [PIW-1:0]       p_waddr;
    logic [EPOCH_W-1:0]   p_wdata, p_rdata;

    hash_ctrl_t           hash_in, hash_out;
    logic [KEY_W-1:0]     hash_key;
    logic [SW-1:0]        hash_slot;

    logic                 s_xfer, out_free, epoch_wrap, obj_big;
    logic                 sweep_done, bkt_valid, key_hit;
    logic [CNT_W-1:0]     bkt_count;
    logic [PW-1:0]        bkt_head, e_link;
    logic [OBJ_W-1:0]     e_obj;
    logic [CW-1:0]        second_inc;
    logic [OBJ_W-1:0]     cmp_lo, cmp_hi;
    logic [15:0]          tri_prod;
    logic [16:0]          pidx_full;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign epoch_wrap = (epoch_reg == EPOCH_LAST);
    assign obj_big    = ({3'b000, s_tdata[7:0]} >= 11'(MAX_OBJECTS));
    assign sweep_done = (!sweep_b_reg || sweep_reg >= T_LAST) &&
                        (!sweep_p_reg || sweep_reg >= P_LAST);

    assign bkt_valid = b_rdata[B_VAL];
    assign bkt_count = b_rdata[CNT_W-1:0];
    assign bkt_head  = b_rdata[B_HEAD +: PW];
    assign key_hit   = (b_rdata[B_KEY +: KEY_W] == hash_key);
    assign e_obj     = e_rdata[OBJ_W+PW-1:PW];
    assign e_link    = e_rdata[PW-1:0];
    assign second_inc = walk_second_reg + CW'(1);

    // pair index of the ordered pair: hi*(hi-1)/2 + lo
    assign cmp_lo    = (obj_a_reg < st_rdata) ? obj_a_reg : st_rdata;
    assign cmp_hi    = (obj_a_reg < st_rdata) ? st_rdata : obj_a_reg;
    assign tri_prod  = 16'(cmp_hi) * 16'(cmp_hi - 8'd1);
    assign pidx_full = 17'(tri_prod[15:1]) + 17'(cmp_lo);

    sbp_hash #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (hash_in),
        .ctrl_out (hash_out),
        .cell_x   (x_reg),
        .cell_y   (y_reg),
        .cell_z   (z_reg),
        .key      (hash_key),
        .slot     (hash_slot)
    );

    sbp_ram #(.WIDTH(BW), .DEPTH(TABLE_SLOTS)) u_bucket_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    sbp_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_active_ram (
        .clk(clk), .we(a_we), .waddr(active_count_reg[SW-1:0]), .wdata(probe_idx_reg),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    sbp_ram #(.WIDTH(OBJ_W + PW), .DEPTH(ENTRY_POOL)) u_entry_ram (
        .clk(clk), .we(e_we), .waddr(pool_used_reg[EIW-1:0]), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    sbp_ram #(.WIDTH(OBJ_W), .DEPTH(MAX_OBJECTS)) u_staged_ram (
        .clk(clk), .we(st_we), .waddr(staged_count_reg[SIW-1:0]), .wdata(e_obj),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    sbp_ram #(.WIDTH(EPOCH_W), .DEPTH(PAIRS)) u_pair_ram (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(pidx_reg), .rdata(p_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP:
            begin
                if (sweep_done)
                begin
                    case (op_reg)
                        OP_CLEAR:  state_next = S_RESULT;
                        OP_INSERT: state_next = S_HASH;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_IDLE:
            begin
                if (s_xfer)
                begin
                    case (op_t'(s_tuser))
                        OP_CLEAR:  state_next = S_SWEEP;
                        OP_INSERT:
                        begin
                            if (obj_big)
                            begin
                                state_next = S_RESULT;
                            end
                            else if (epoch_wrap)
                            begin
                                state_next = S_SWEEP;
                            end
                            else
                            begin
                                state_next = S_HASH;
                            end
                        end
                        OP_PAIR:   state_next = S_PAIR_POS;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_HASH:
            begin
                state_next = S_HASH_WAIT;
            end
            S_HASH_WAIT:
            begin
                if (hash_out.done)
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (!bkt_valid)
                begin
                    state_next = (active_count_reg < SLOTS_A) ? S_CHAIN_RD : S_RESULT;
                end
                else if (key_hit)
                begin
                    state_next = S_CHAIN_RD;
                end
                else if (probe_cnt_reg + AW'(1) == SLOTS_A)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_CHAIN_RD:
            begin
                state_next = (cur_reg < pool_used_reg) ? S_CHAIN_CHK : S_INS_WRITE;
            end
            S_CHAIN_CHK:
            begin
                state_next = (e_obj == obj_reg) ? S_RESULT : S_CHAIN_RD;
            end
            S_INS_WRITE:
            begin
                state_next = S_RESULT;
            end
            S_PAIR_POS:
            begin
                if (staged_count_reg != '0)
                begin
                    state_next = S_WALK;
                end
                else if (walk_pos_reg >= active_count_reg)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_ACT_RD;
                end
            end
            S_ACT_RD:
            begin
                state_next = S_BKT_RD;
            end
            S_BKT_RD:
            begin
                state_next = S_BKT_CHK;
            end
            S_BKT_CHK:
            begin
                state_next = (!bkt_valid || bkt_count < CNT_W'(2)) ? S_PAIR_POS : S_STAGE_RD;
            end
            S_STAGE_RD:
            begin
                if (cur_reg < pool_used_reg && staged_count_reg < MAX_C)
                begin
                    state_next = S_STAGE_CHK;
                end
                else if (staged_count_reg < CW'(2))
                begin
                    state_next = S_PAIR_POS;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_STAGE_CHK:
            begin
                state_next = S_STAGE_RD;
            end
            S_WALK:
            begin
                if (walk_first_reg + CW'(1) >= staged_count_reg ||
                    walk_second_reg >= staged_count_reg)
                begin
                    state_next = S_PAIR_POS;
                end
                else
                begin
                    state_next = S_READ_C;
                end
            end
            S_READ_C:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = (obj_a_reg == st_rdata) ? S_WALK : S_SEEN_RD;
            end
            S_SEEN_RD:
            begin
                state_next = S_SEEN_CHK;
            end
            S_SEEN_CHK:
            begin
                state_next = (p_rdata == epoch_reg) ? S_WALK : S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        b_we     = 1'b0;
        b_waddr  = probe_idx_reg;
        b_wdata  = '0;
        b_raddr  = probe_idx_reg;
        a_we     = 1'b0;
        a_raddr  = walk_pos_reg[SW-1:0];
        e_we     = 1'b0;
        e_raddr  = cur_reg[EIW-1:0];
        e_wdata  = {obj_reg, head_reg};
        st_we    = 1'b0;
        st_raddr = walk_first_reg[SIW-1:0];
        p_we     = 1'b0;
        p_waddr  = pidx_reg;
        p_wdata  = epoch_reg;
        hash_in.start = (state_reg == S_HASH);
        hash_in.done  = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                b_we    = sweep_b_reg && sweep_reg <= T_LAST;
                b_waddr = sweep_reg[SW-1:0];
                p_we    = sweep_p_reg && sweep_reg <= P_LAST;
                p_waddr = sweep_reg[PIW-1:0];
                p_wdata = '0;
            end
            S_PROBE_CHK:
            begin
                // new bucket with an empty chain
                if (!bkt_valid && active_count_reg < SLOTS_A)
                begin
                    b_we    = 1'b1;
                    b_wdata = {1'b1, hash_key, CHAIN_END, CNT_W'(0)};
                    a_we    = 1'b1;
                end
            end
            S_INS_WRITE:
            begin
                if (pool_used_reg < CHAIN_END)
                begin
                    b_we    = 1'b1;
                    b_wdata = {1'b1, hash_key, pool_used_reg, count_reg + CNT_W'(1)};
                    e_we    = 1'b1;
                end
            end
            S_BKT_RD:
            begin
                b_raddr = a_rdata;
            end
            S_STAGE_CHK:
            begin
                st_we = 1'b1;
            end
            S_READ_C:
            begin
                st_raddr = walk_second_reg[SIW-1:0];
            end
            S_SEEN_CHK:
            begin
                p_we = (p_rdata != epoch_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_SWEEP;
            op_reg           <= OP_NOP;
            obj_reg          <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            z_reg            <= '0;
            sweep_reg        <= '0;
            sweep_b_reg      <= 1'b1;
            sweep_p_reg      <= 1'b1;
            epoch_reg        <= EPOCH_FIRST;
            probe_idx_reg    <= '0;
            probe_cnt_reg    <= '0;
            head_reg         <= '0;
            cur_reg          <= '0;
            count_reg        <= '0;
            active_count_reg <= '0;
            walk_pos_reg     <= '0;
            pool_used_reg    <= '0;
            walk_first_reg   <= '0;
            walk_second_reg  <= '0;
            staged_count_reg <= '0;
            obj_a_reg        <= '0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            pidx_reg         <= '0;
            res_status_reg   <= ST_CLEARED;
            res_low_reg      <= '0;
            res_high_reg     <= '0;
            res_occ_reg      <= '0;
            m_valid_reg      <= 1'b0;
            m_user_reg       <= '0;
            m_data_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + SWW'(1);
                end
                S_IDLE:
                begin
                    if (s_xfer)
                    begin
                        op_reg         <= op_t'(s_tuser);
                        obj_reg        <= s_tdata[7:0];
                        x_reg          <= s_tdata[23:8];
                        y_reg          <= s_tdata[39:24];
                        z_reg          <= s_tdata[55:40];
                        res_status_reg <= ST_CLEARED;
                        res_low_reg    <= '0;
                        res_high_reg   <= '0;
                        res_occ_reg    <= '0;
                        sweep_reg      <= '0;
                        if (op_t'(s_tuser) == OP_CLEAR ||
                            (op_t'(s_tuser) == OP_INSERT && !obj_big))
                        begin
                            // new frame for the pair walk
                            epoch_reg        <= epoch_wrap ? EPOCH_FIRST : epoch_reg + 8'd1;
                            sweep_p_reg      <= epoch_wrap;
                            sweep_b_reg      <= (op_t'(s_tuser) == OP_CLEAR);
                            walk_pos_reg     <= '0;
                            walk_first_reg   <= '0;
                            walk_second_reg  <= '0;
                            staged_count_reg <= '0;
                        end
                        if (op_t'(s_tuser) == OP_CLEAR)
                        begin
                            active_count_reg <= '0;
                            pool_used_reg    <= '0;
                        end
                        if (op_t'(s_tuser) == OP_INSERT && obj_big)
                        begin
                            res_status_reg <= ST_POOL_FULL;
                        end
                    end
                end
                S_HASH_WAIT:
                begin
                    probe_idx_reg <= hash_slot;
                    probe_cnt_reg <= '0;
                end
                S_PROBE_CHK:
                begin
                    if (!bkt_valid)
                    begin
                        if (active_count_reg < SLOTS_A)
                        begin
                            active_count_reg <= active_count_reg + AW'(1);
                            head_reg         <= CHAIN_END;
                            cur_reg          <= CHAIN_END;
                            count_reg        <= '0;
                        end
                        else
                        begin
                            res_status_reg <= ST_TABLE_FULL;
                        end
                    end
                    else if (key_hit)
                    begin
                        head_reg  <= bkt_head;
                        cur_reg   <= bkt_head;
                        count_reg <= bkt_count;
                    end
                    else
                    begin
                        probe_cnt_reg <= probe_cnt_reg + AW'(1);
                        probe_idx_reg <= (probe_idx_reg == SLOT_LAST) ? '0 :
                                         probe_idx_reg + SW'(1);
                        if (probe_cnt_reg + AW'(1) == SLOTS_A)
                        begin
                            res_status_reg <= ST_TABLE_FULL;
                        end
                    end
                end
                S_CHAIN_CHK:
                begin
                    cur_reg <= e_link;
                    if (e_obj == obj_reg)
                    begin
                        res_status_reg <= ST_PRESENT;
                        res_occ_reg    <= count_reg;
                    end
                end
                S_INS_WRITE:
                begin
                    if (pool_used_reg < CHAIN_END)
                    begin
                        pool_used_reg  <= pool_used_reg + PW'(1);
                        res_status_reg <= ST_INSERTED;
                        res_occ_reg    <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status_reg <= ST_POOL_FULL;
                        res_occ_reg    <= count_reg;
                    end
                end
                S_PAIR_POS:
                begin
                    if (staged_count_reg == '0 && walk_pos_reg >= active_count_reg)
                    begin
                        res_status_reg <= ST_NO_PAIR;
                    end
                end
                S_BKT_CHK:
                begin
                    if (!bkt_valid || bkt_count < CNT_W'(2))
                    begin
                        walk_pos_reg <= walk_pos_reg + AW'(1);
                    end
                    else
                    begin
                        cur_reg          <= bkt_head;
                        staged_count_reg <= '0;
                    end
                end
                S_STAGE_RD:
                begin
                    if (!(cur_reg < pool_used_reg && staged_count_reg < MAX_C))
                    begin
                        walk_first_reg  <= '0;
                        walk_second_reg <= CW'(1);
                        if (staged_count_reg < CW'(2))
                        begin
                            staged_count_reg <= '0;
                            walk_pos_reg     <= walk_pos_reg + AW'(1);
                        end
                    end
                end
                S_STAGE_CHK:
                begin
                    staged_count_reg <= staged_count_reg + CW'(1);
                    cur_reg          <= e_link;
                end
                S_WALK:
                begin
                    if (walk_first_reg + CW'(1) >= staged_count_reg ||
                        walk_second_reg >= staged_count_reg)
                    begin
                        staged_count_reg <= '0;
                        walk_pos_reg     <= walk_pos_reg + AW'(1);
                    end
                end
                S_READ_C:
                begin
                    obj_a_reg <= st_rdata;
                    if (second_inc >= staged_count_reg)
                    begin
                        walk_first_reg  <= walk_first_reg + CW'(1);
                        walk_second_reg <= walk_first_reg + CW'(2);
                    end
                    else
                    begin
                        walk_second_reg <= second_inc;
                    end
                end
                S_CMP:
                begin
                    lo_reg   <= cmp_lo;
                    hi_reg   <= cmp_hi;
                    pidx_reg <= PIW'(pidx_full);
                end
                S_SEEN_CHK:
                begin
                    if (p_rdata != epoch_reg)
                    begin
                        res_status_reg <= ST_PAIR;
                        res_low_reg    <= lo_reg;
                        res_high_reg   <= hi_reg;
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= res_status_reg;
                        m_data_reg  <= {7'd0, res_occ_reg, res_high_reg, res_low_reg};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pool_used_reg <= CHAIN_END)
        else $error("entry pool count beyond pool size");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_count_reg <= SLOTS_A)
        else $error("active bucket count beyond table size");

    a_staged_bound: assert property (@(posedge clk) disable iff (!rst_n)
        staged_count_reg <= MAX_C)
        else $error("staged object count beyond object limit");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_free && res_status_reg == ST_PAIR)
        |=> (m_tdata[7:0] < m_tdata[15:8]))
        else $error("pair result not strictly ordered");

    a_probe_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_CHK) |-> (probe_cnt_reg < SLOTS_A))
        else $error("probe count ran past table size");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import sbp_pkg::*;

    localparam int TBL   = 1024;
    localparam int POOL  = 4096;
    localparam int MAXO  = 256;
    localparam int NPAIR = MAXO * (MAXO - 1) / 2;
    localparam int RANDOM_ITEMS = 1750;

    typedef struct {
        op_t         op;
        logic [7:0]  obj;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } grid_req_t;

    typedef struct {
        status_t     st;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [8:0]  occ;
    } grid_rsp_t;

    typedef struct {
        grid_req_t   rq;
        bit          typed;
        grid_rsp_t   rs;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    spatial_hash_broadphase_pairs_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicted grid state
    bit          bkt_used [TBL];
    longint      bkt_key  [TBL];
    int          bkt_head [TBL];
    int          bkt_cnt  [TBL];
    int          act_list [TBL];
    int          act_n;
    int          ent_obj  [POOL];
    int          ent_next [POOL];
    int          pool_n;
    int          seen_gen [NPAIR];
    int          gen;
    int          walk_pos;
    int          walk_a;
    int          walk_b;
    int          staged   [MAXO];
    int          staged_n;

    grid_rsp_t   pending_rsp [$];
    int          fails;
    int          rsp_seen;
    int          burst_left;
    bit          in_random;
    bit          holding;
    bit          pressure_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    task automatic restart_pairs();
        gen      = gen + 1;
        walk_pos = 0;
        walk_a   = 0;
        walk_b   = 0;
        staged_n = 0;
    endtask

    task automatic grid_predict(input grid_req_t rq, output grid_rsp_t rs);
        longint key;
        int     slot;
        int     b;
        int     probe;
        int     cur;
        int     steps;
        int     a;
        int     c;
        int     t;
        int     pidx;
        bit     found;
        bit     done;
        rs.st  = ST_CLEARED;
        rs.lo  = '0;
        rs.hi  = '0;
        rs.occ = '0;
        case (rq.op)
            OP_CLEAR:
            begin
                for (int i = 0; i < TBL; i++)
                    bkt_used[i] = 1'b0;
                act_n  = 0;
                pool_n = 0;
                restart_pairs();
            end
            OP_INSERT:
            begin
                key = (longint'($signed(rq.x)) * 64'sd73856093)
                    ^ (longint'($signed(rq.y)) * 64'sd19349663)
                    ^ (longint'($signed(rq.z)) * 64'sd83492791);
                restart_pairs();
                slot = int'(key[9:0]);
                b    = -1;
                for (probe = 0; probe < TBL && b < 0; probe++)
                begin
                    if (!bkt_used[slot])
                    begin
                        bkt_used[slot] = 1'b1;
                        bkt_key[slot]  = key;
                        bkt_head[slot] = POOL;
                        bkt_cnt[slot]  = 0;
                        act_list[act_n] = slot;
                        act_n = act_n + 1;
                        b = slot;
                    end
                    else if (bkt_key[slot] == key)
                        b = slot;
                    else
                        slot = (slot + 1) % TBL;
                end
                if (b < 0)
                    rs.st = ST_TABLE_FULL;
                else
                begin
                    cur   = bkt_head[b];
                    found = 1'b0;
                    for (steps = 0; cur < pool_n && steps < POOL && !found; steps++)
                    begin
                        if (ent_obj[cur] == int'(rq.obj))
                            found = 1'b1;
                        else
                            cur = ent_next[cur];
                    end
                    if (found)
                        rs.st = ST_PRESENT;
                    else if (pool_n < POOL)
                    begin
                        ent_obj[pool_n]  = int'(rq.obj);
                        ent_next[pool_n] = bkt_head[b];
                        bkt_head[b]      = pool_n;
                        pool_n           = pool_n + 1;
                        bkt_cnt[b]       = bkt_cnt[b] + 1;
                        rs.st = ST_INSERTED;
                    end
                    else
                        rs.st = ST_POOL_FULL;
                    rs.occ = 9'(bkt_cnt[b]);
                end
            end
            OP_PAIR:
            begin
                done = 1'b0;
                while (!done)
                begin
                    if (staged_n == 0)
                    begin
                        if (walk_pos >= act_n)
                        begin
                            rs.st = ST_NO_PAIR;
                            done  = 1'b1;
                            continue;
                        end
                        b = act_list[walk_pos];
                        if (!bkt_used[b] || bkt_cnt[b] < 2)
                        begin
                            walk_pos = walk_pos + 1;
                            continue;
                        end
                        cur   = bkt_head[b];
                        steps = 0;
                        while (cur < pool_n && steps < POOL && staged_n < MAXO)
                        begin
                            staged[staged_n] = ent_obj[cur];
                            staged_n = staged_n + 1;
                            cur      = ent_next[cur];
                            steps    = steps + 1;
                        end
                        walk_a = 0;
                        walk_b = 1;
                        if (staged_n < 2)
                        begin
                            staged_n = 0;
                            walk_pos = walk_pos + 1;
                            continue;
                        end
                    end
                    if (walk_a + 1 >= staged_n || walk_b >= staged_n)
                    begin
                        staged_n = 0;
                        walk_pos = walk_pos + 1;
                        continue;
                    end
                    a = staged[walk_a];
                    c = staged[walk_b];
                    walk_b = walk_b + 1;
                    if (walk_b >= staged_n)
                    begin
                        walk_a = walk_a + 1;
                        walk_b = walk_a + 1;
                    end
                    // objects never repeat within a chain, so this guards only the self pair
                    if (a == c)
                        continue;
                    if (a > c)
                    begin
                        t = a;
                        a = c;
                        c = t;
                    end
                    pidx = c * (c - 1) / 2 + a;
                    if (seen_gen[pidx] == gen)
                        continue;
                    seen_gen[pidx] = gen;
                    rs.st = ST_PAIR;
                    rs.lo = 8'(a);
                    rs.hi = 8'(c);
                    done  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_op(input grid_req_t rq, input bit typed, input grid_rsp_t want);
        grid_rsp_t got;
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {8'd0, rq.z, rq.y, rq.x, rq.obj};
        do
            @(posedge clk);
        while (!s_tready);
        if (rq.op != OP_NOP)
        begin
            grid_predict(rq, got);
            pending_rsp.push_back(typed ? want : got);
        end
        if (burst_left > 0)
            burst_left = burst_left - 1;
        else if (!holding)
        begin
            // long bursts now and then give stretches with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 10);
            if ($urandom_range(0, 1) == 1)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    function automatic grid_req_t mk_req(op_t op, int obj, int x, int y, int z);
        grid_req_t rq;
        rq.op  = op;
        rq.obj = 8'(obj);
        rq.x   = 16'(x);
        rq.y   = 16'(y);
        rq.z   = 16'(z);
        return rq;
    endfunction

    function automatic grid_rsp_t mk_rsp(status_t st, int occ);
        grid_rsp_t rs;
        rs.st  = st;
        rs.lo  = '0;
        rs.hi  = '0;
        rs.occ = 9'(occ);
        return rs;
    endfunction

    // receiver with its own stall pattern and one long hold-off
    initial
    begin
        int cyc;
        cyc = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc = cyc + 1;
            if (!pressure_done && in_random && rsp_seen > 4300)
            begin
                pressure_done = 1'b1;
                holding = 1'b1;
                m_tready <= 1'b0;
                repeat (800) @(posedge clk);
                holding = 1'b0;
            end
            else
                m_tready <= (cyc % 1024 >= 700) || ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        grid_rsp_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            rsp_seen <= rsp_seen + 1;
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected transfer: status %0d", m_tuser);
                fails <= fails + 1;
            end
            else
            begin
                w = pending_rsp.pop_front();
                if (m_tuser !== w.st)
                begin
                    $error("status: expected %0d, got %0d", w.st, m_tuser);
                    fails <= fails + 1;
                end
                if (m_tdata[7:0] !== w.lo)
                begin
                    $error("object_low: expected %0d, got %0d", w.lo, m_tdata[7:0]);
                    fails <= fails + 1;
                end
                if (m_tdata[15:8] !== w.hi)
                begin
                    $error("object_high: expected %0d, got %0d", w.hi, m_tdata[15:8]);
                    fails <= fails + 1;
                end
                if (m_tdata[24:16] !== w.occ)
                begin
                    $error("cell_occupancy: expected %0d, got %0d", w.occ, m_tdata[24:16]);
                    fails <= fails + 1;
                end
            end
        end
    end

    initial
    begin
        #400000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        table_row_t rows [$];
        grid_rsp_t  none;
        grid_req_t  rq;
        int         n_rand;
        int         base;
        int         cx [3];
        int         cy [3];
        int         cz [3];
        int         k;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_NOP;
        rst_n    = 1'b0;
        fails    = 0;
        rsp_seen = 0;
        gen      = 1;
        act_n    = 0;
        pool_n   = 0;
        burst_left    = 0;
        in_random     = 1'b0;
        holding       = 1'b0;
        pressure_done = 1'b0;
        for (int i = 0; i < NPAIR; i++)
            seen_gen[i] = 0;
        for (int i = 0; i < TBL; i++)
            bkt_used[i] = 1'b0;
        restart_pairs();
        none = mk_rsp(ST_CLEARED, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{mk_req(OP_PAIR, 0, 0, 0, 0), 1, mk_rsp(ST_NO_PAIR, 0)});
        rows.push_back('{mk_req(OP_CLEAR, 255, -1, -1, -1), 1, mk_rsp(ST_CLEARED, 0)});
        rows.push_back('{mk_req(OP_INSERT, 0, 0, 0, 0), 1, mk_rsp(ST_INSERTED, 1)});
        rows.push_back('{mk_req(OP_INSERT, 0, 0, 0, 0), 1, mk_rsp(ST_PRESENT, 1)});
        rows.push_back('{mk_req(OP_INSERT, 255, 0, 0, 0), 1, mk_rsp(ST_INSERTED, 2)});
        rows.push_back('{mk_req(OP_INSERT, 255, -32768, -32768, -32768), 1,
                         mk_rsp(ST_INSERTED, 1)});
        rows.push_back('{mk_req(OP_INSERT, 0, -32768, -32768, -32768), 1,
                         mk_rsp(ST_INSERTED, 2)});
        rows.push_back('{mk_req(OP_INSERT, 0, 32767, 32767, 32767), 1, mk_rsp(ST_INSERTED, 1)});
        rows.push_back('{mk_req(OP_INSERT, 7, 32767, 32767, 32767), 1, mk_rsp(ST_INSERTED, 2)});
        rows.push_back('{mk_req(OP_NOP, 170, 21845, -21846, 4660), 0, none});
        // the pair 0/255 sits in two cells and must come out once
        for (int i = 0; i < 4; i++)
            rows.push_back('{mk_req(OP_PAIR, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk_req(OP_INSERT, 7, 0, 0, 0), 1, mk_rsp(ST_INSERTED, 3)});
        for (int i = 0; i < 5; i++)
            rows.push_back('{mk_req(OP_PAIR, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk_req(OP_CLEAR, 0, 0, 0, 0), 1, mk_rsp(ST_CLEARED, 0)});
        rows.push_back('{mk_req(OP_PAIR, 0, 0, 0, 0), 1, mk_rsp(ST_NO_PAIR, 0)});

        foreach (rows[i])
            send_op(rows[i].rq, rows[i].typed, rows[i].rs);

        // fill every slot of the table, then the entry pool
        for (int i = 0; i < TBL; i++)
            send_op(mk_req(OP_INSERT, 0, i, 0, 0), 0, none);
        send_op(mk_req(OP_INSERT, 0, 0, 1, 0), 1, mk_rsp(ST_TABLE_FULL, 0));
        for (int j = 1; j < 4; j++)
            for (int i = 0; i < TBL; i++)
                send_op(mk_req(OP_INSERT, j, i, 0, 0), 0, none);
        send_op(mk_req(OP_INSERT, 9, 5, 0, 0), 1, mk_rsp(ST_POOL_FULL, 4));
        send_op(mk_req(OP_INSERT, 2, 5, 0, 0), 1, mk_rsp(ST_PRESENT, 4));
        send_op(mk_req(OP_CLEAR, 0, 0, 0, 0), 1, mk_rsp(ST_CLEARED, 0));

        in_random = 1'b1;
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                // a frame: a few inserts over a handful of cells, then walk the pairs
                base = $urandom_range(0, 255);
                for (int i = 0; i < 3; i++)
                begin
                    cx[i] = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 3);
                    cy[i] = $urandom_range(0, 65535);
                    cz[i] = $urandom_range(0, 65535);
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    send_op(mk_req(OP_CLEAR, $urandom_range(0, 255), 0, 0, 0), 0, none);
                    n_rand = n_rand + 1;
                end
                k = $urandom_range(1, 8);
                for (int i = 0; i < k; i++)
                begin
                    int c;
                    c = $urandom_range(0, 2);
                    send_op(mk_req(OP_INSERT, (base + $urandom_range(0, 7)) % 256,
                                   cx[c], cy[c], cz[c]), 0, none);
                end
                k = $urandom_range(1, 25);
                for (int i = 0; i < k; i++)
                    send_op(mk_req(OP_PAIR, $urandom_range(0, 255),
                                   $urandom_range(0, 65535), 0, 0), 0, none);
                n_rand = n_rand + 8;
            end
            else
            begin
                rq = mk_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
                send_op(rq, 0, none);
                if (rq.op != OP_NOP)
                    n_rand = n_rand + 1;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fails == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
